// File: sv/ttw_pkg.sv
`timescale 1ns / 1ps

package ttw_pkg;

    typedef enum logic [1:0] {
        ACT_PUT        = 2'd0,
        ACT_CLEAR      = 2'd1,
        ACT_CLEAR_HOME = 2'd2,
        ACT_READ       = 2'd3
    } t_action;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] RESET_ATTR   = 8'h0F;

    localparam int CELL_W    = 16;
    localparam int IN_ROW_W  = 5;
    localparam int IN_COL_W  = 7;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;
    localparam int IN_DATA_W = 24;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 32;

    localparam logic REG_TEXT_COLOR = 1'b0;

    typedef struct packed {
        logic load_item;
        logic exec_put;
        logic home;
        logic sweep_start;
        logic sweep_step;
        logic sweep_copy;
        logic fill_reset;
        logic rd_issue;
        logic rd_capture;
        logic set_scroll;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    need_scroll;
        logic    sweep_last;
        logic    out_free;
    } t_dp_stat;

endpackage

// File: sv/text_terminal_writer.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid/tready             tdata char/row/col, tuser action
// m_axis    out  tvalid/tready             tdata cell/row/col/scrolled
// apb       in   psel/penable/pwrite       text_color at byte address 0
//
// Put character: EXEC then DONE; read: RAM read in EXEC, capture in READ, then DONE.
// Clear and scroll sweep the screen memory, one cell per cycle, bound by the single
// write port of the screen RAM.
// After reset the block fills the screen with 0x0F20 while tready is low;
// configuration writes are taken throughout.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken, and the next result holds until that register drains.

module text_terminal_writer import ttw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // char_code, read_row, read_col
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,  // action
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // cell_value, cursor_row, cursor_col,
                                                   // scrolled
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_AW-1:0]     i_paddr,
    input  logic [CFG_DW-1:0]     i_pwdata,
    output logic [CFG_DW-1:0]     o_prdata,
    output logic                  o_pready
);

    logic [7:0]          r_text_color;
    t_dp_cmd             cmd;
    t_dp_stat            stat;
    logic [CELL_W-1:0]   cell_value;
    logic [IN_ROW_W-1:0] cursor_row;
    logic [IN_COL_W-1:0] cursor_col;
    logic                scrolled;
    logic                reg_sel;

    assign reg_sel  = (i_paddr[2] == REG_TEXT_COLOR);
    assign o_pready = 1'b1;
    assign o_prdata = reg_sel ? CFG_DW'(r_text_color) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_ATTR;
        end else if (i_psel && i_penable && i_pwrite && reg_sel) begin
            r_text_color <= i_pwdata[7:0];
        end
    end

    ttw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ttw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_text_color  (r_text_color),
        .i_item_action (i_s_axis_tuser),
        .i_item_char   (i_s_axis_tdata[7:0]),
        .i_item_row    (i_s_axis_tdata[12:8]),
        .i_item_col    (i_s_axis_tdata[19:13]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_cell_value  (cell_value),
        .o_cursor_row  (cursor_row),
        .o_cursor_col  (cursor_col),
        .o_scrolled    (scrolled)
    );

    assign o_m_axis_tdata = {3'b000, scrolled, cursor_col, cursor_row, cell_value};

endmodule

// File: sv/ttw_ram.sv
`timescale 1ns / 1ps

module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ttw_ctrl.sv
`timescale 1ns / 1ps

module ttw_ctrl import ttw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_INIT     = 8'b0000_0001,
        S_RST_FILL = 8'b0000_0010,
        S_IDLE     = 8'b0000_0100,
        S_EXEC     = 8'b0000_1000,
        S_READ     = 8'b0001_0000,
        S_FILL     = 8'b0010_0000,
        S_SCROLL   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_start = 1'b1;
                o_cmd.fill_reset  = 1'b1;
                n_state           = S_RST_FILL;
            end
            S_RST_FILL: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.action) inside
                    ACT_PUT: begin
                        o_cmd.exec_put = 1'b1;
                        if (i_stat.need_scroll) begin
                            o_cmd.sweep_start = 1'b1;
                            o_cmd.set_scroll  = 1'b1;
                            n_state           = S_SCROLL;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    ACT_CLEAR, ACT_CLEAR_HOME: begin
                        o_cmd.sweep_start = 1'b1;
                        o_cmd.home        = (i_stat.action == ACT_CLEAR_HOME);
                        n_state           = S_FILL;
                    end
                    default: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_READ;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_DONE;
            end
            S_FILL: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_SCROLL: begin
                o_cmd.sweep_step = 1'b1;
                o_cmd.sweep_copy = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/ttw_dp.sv
`timescale 1ns / 1ps

module ttw_dp import ttw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [7:0]          i_text_color,
    input  logic [1:0]          i_item_action,
    input  logic [7:0]          i_item_char,
    input  logic [IN_ROW_W-1:0] i_item_row,
    input  logic [IN_COL_W-1:0] i_item_col,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [CELL_W-1:0]   o_cell_value,
    output logic [IN_ROW_W-1:0] o_cursor_row,
    output logic [IN_COL_W-1:0] o_cursor_col,
    output logic                o_scrolled
);

    localparam int NCELLS   = ROWS * COLUMNS;
    localparam int AW       = $clog2(NCELLS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int COPY_END = NCELLS - COLUMNS;

    t_action             r_action;
    logic [7:0]          r_char;
    logic [IN_ROW_W-1:0] r_rrow;
    logic [IN_COL_W-1:0] r_rcol;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [AW-1:0]       r_ptr;
    logic [CELL_W-1:0]   r_fill;
    logic                r_wr_en;
    logic [AW-1:0]       r_wr_addr;
    logic                r_wr_copy;
    logic [CELL_W-1:0]   r_wr_data;
    logic [CELL_W-1:0]   r_cell;
    logic                r_scrolled;
    logic                r_out_valid;
    logic [CELL_W-1:0]   r_out_cell;
    logic [IN_ROW_W-1:0] r_out_row;
    logic [IN_COL_W-1:0] r_out_col;
    logic                r_out_scrolled;

    logic                is_nl;
    logic                is_bs;
    logic                last_row;
    logic                last_col;
    logic [COL_W-1:0]    col_target;
    logic [ROW_W-1:0]    row_adv;
    logic [AW-1:0]       cur_addr;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       copy_addr;
    logic [AW-1:0]       ram_raddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [CELL_W-1:0]   ram_rdata;
    logic                in_range;

    assign is_nl    = (r_char == CH_NEWLINE);
    assign is_bs    = (r_char == CH_BACKSPACE);
    assign last_row = (r_row == ROW_W'(ROWS - 1));
    assign last_col = (r_col == COL_W'(COLUMNS - 1));
    assign row_adv  = last_row ? r_row : r_row + ROW_W'(1);

    always_comb begin
        col_target = r_col;
        if (is_bs && (r_col != '0)) begin
            col_target = r_col - COL_W'(1);
        end
    end

    assign cur_addr  = AW'(32'(r_row) * 32'(COLUMNS) + 32'(col_target));
    assign rd_addr   = AW'(32'(r_rrow) * 32'(COLUMNS) + 32'(r_rcol));
    assign copy_addr = AW'(32'(r_ptr) + 32'(COLUMNS));
    assign in_range  = (32'(r_rrow) < 32'(ROWS)) && (32'(r_rcol) < 32'(COLUMNS));
    assign ram_raddr = i_cmd.rd_issue ? rd_addr : copy_addr;
    assign ram_wdata = r_wr_copy ? ram_rdata : r_wr_data;

    assign o_stat.action      = r_action;
    assign o_stat.need_scroll = (r_action == ACT_PUT) && last_row
                                && (is_nl || (!is_bs && last_col));
    assign o_stat.sweep_last  = (32'(r_ptr) == NCELLS - 1);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    ttw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NCELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (r_wr_en),
        .i_waddr (r_wr_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_ptr       <= '0;
            r_wr_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_en <= 1'b0;
            if (i_cmd.exec_put) begin
                if (is_nl) begin
                    r_col <= '0;
                    r_row <= row_adv;
                end else if (is_bs) begin
                    r_col <= col_target;
                end else if (last_col) begin
                    r_col <= '0;
                    r_row <= row_adv;
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
                r_wr_en <= !is_nl;
            end
            if (i_cmd.home) begin
                r_row <= '0;
                r_col <= '0;
            end
            if (i_cmd.sweep_start) begin
                r_ptr <= '0;
            end else if (i_cmd.sweep_step) begin
                r_ptr   <= r_ptr + AW'(1);
                r_wr_en <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action   <= t_action'(i_item_action);
            r_char     <= i_item_char;
            r_rrow     <= i_item_row;
            r_rcol     <= i_item_col;
            r_cell     <= '0;
            r_scrolled <= 1'b0;
        end
        if (i_cmd.exec_put) begin
            r_wr_addr <= cur_addr;
            r_wr_copy <= 1'b0;
            r_wr_data <= {i_text_color, is_bs ? CH_SPACE : r_char};
        end
        if (i_cmd.sweep_start) begin
            r_fill <= {i_cmd.fill_reset ? RESET_ATTR : i_text_color, CH_SPACE};
        end
        if (i_cmd.sweep_step) begin
            r_wr_addr <= r_ptr;
            r_wr_copy <= i_cmd.sweep_copy && (32'(r_ptr) < COPY_END);
            r_wr_data <= r_fill;
        end
        if (i_cmd.set_scroll) begin
            r_scrolled <= 1'b1;
        end
        if (i_cmd.rd_capture) begin
            r_cell <= in_range ? ram_rdata : '0;
        end
        if (i_cmd.out_load) begin
            r_out_cell     <= r_cell;
            r_out_row      <= IN_ROW_W'(r_row);
            r_out_col      <= IN_COL_W'(r_col);
            r_out_scrolled <= r_scrolled;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_cell;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_scrolled   = r_out_scrolled;

endmodule
